// ----- design/assert_macros.svh -----
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlsd assertion failed");

`endif

// ----- design/rlsd_pkg.sv -----
// Package with the result record, result kinds and color widening helpers of the decoder.
package rlsd_pkg;

    localparam int MAX_SIDE_DEF = 4096;

    localparam int WORD_W  = 16;
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int DIM_W   = 13;
    localparam int TDATA_W = 80;
    localparam int TUSER_W = 3;

    localparam logic [DIM_W-1:0] DIM_SAT = 13'd8191;

    // Reciprocal constants: v * 255 / 31 and v * 255 / 63, scaled by 2^20.
    localparam logic [28:0] RB_MUL = 29'd8625630;
    localparam logic [28:0] G_MUL  = 29'd4244475;

    typedef enum logic [2:0] {
        KIND_PIXEL    = 3'd0,
        KIND_DIMS     = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_BAD_DIMS = 3'd3,
        KIND_TRUNC    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [DIM_W-1:0]   img_width;
        logic [DIM_W-1:0]   img_height;
        logic               final_result;
    } t_result;

    function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
        logic [28:0] prod;
        prod = 29'(v) * RB_MUL;
        return prod[27:20];
    endfunction

    function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] v);
        logic [28:0] prod;
        prod = 29'(v) * G_MUL;
        return prod[27:20];
    endfunction

    function automatic logic [DIM_W-1:0] sat13(input logic [WORD_W-1:0] v);
        return (v > 16'(DIM_SAT)) ? DIM_SAT : DIM_W'(v);
    endfunction

endpackage

// ----- design/rlsd_core.sv -----
// Blob parser: phase sequencer, counters and the results caused by one word.
module rlsd_core #(
    parameter int MAX_SIDE = rlsd_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [rlsd_pkg::WORD_W-1:0] i_word,
    input  logic                        i_last,
    output rlsd_pkg::t_result           o_res0,
    output rlsd_pkg::t_result           o_res1,
    output logic [1:0]                  o_count
);

    localparam int POS_W = $clog2(MAX_SIDE + 1);
    localparam logic [16:0] MAX_WIDE = 17'(MAX_SIDE);

    typedef enum logic [3:0] {
        PH_WIDTH, PH_HEIGHT, PH_LINELEN, PH_SEGCNT, PH_SKIP,
        PH_KEYCNT, PH_KEYPIX, PH_PIXCNT, PH_PIX, PH_IDLE
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [rlsd_pkg::WORD_W-1:0] r_width, n_width;
    logic [rlsd_pkg::WORD_W-1:0] r_height, n_height;
    logic [POS_W-1:0]            r_row, n_row;
    logic [rlsd_pkg::WORD_W-1:0] r_seg, n_seg;
    logic [rlsd_pkg::WORD_W-1:0] r_run, n_run;
    logic [POS_W-1:0]            r_column, n_column;

    logic              pixel_step;
    logic              pixel_hit;
    logic              dim_res;
    logic              bad_res;
    logic              complete;
    logic              trunc;
    logic              finished;
    logic              do_seg;
    logic              do_line;
    logic [16:0]       skip_sum;
    logic [POS_W-1:0]  row_inc;
    rlsd_pkg::t_result res_prim;
    rlsd_pkg::t_result res_done;
    rlsd_pkg::t_result res_trunc;
    rlsd_pkg::t_result res_second;
    logic              has_prim;

    always_comb begin
        n_phase    = r_phase;
        n_width    = r_width;
        n_height   = r_height;
        n_row      = r_row;
        n_seg      = r_seg;
        n_run      = r_run;
        n_column   = r_column;
        pixel_step = 1'b0;
        dim_res    = 1'b0;
        bad_res    = 1'b0;
        complete   = 1'b0;
        trunc      = 1'b0;
        finished   = 1'b0;
        do_seg     = 1'b0;
        do_line    = 1'b0;
        skip_sum   = 17'(r_column) + 17'(i_word);
        row_inc    = r_row + 1'b1;

        unique case (r_phase)
            PH_WIDTH: begin
                n_width  = i_word;
                n_height = '0;
                n_phase  = PH_HEIGHT;
            end
            PH_HEIGHT: begin
                n_height = i_word;
                if ((r_width == '0) || (i_word == '0) ||
                    (17'(r_width) > MAX_WIDE) || (17'(i_word) > MAX_WIDE)) begin
                    bad_res  = 1'b1;
                    finished = 1'b1;
                    n_phase  = PH_IDLE;
                end else begin
                    dim_res = 1'b1;
                    n_row   = '0;
                    n_phase = PH_LINELEN;
                end
            end
            PH_LINELEN: begin
                n_phase = PH_SEGCNT;
            end
            PH_SEGCNT: begin
                n_seg    = i_word;
                n_column = '0;
                if (i_word == '0) begin
                    do_line = 1'b1;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_column = (skip_sum > MAX_WIDE) ? POS_W'(MAX_SIDE) : POS_W'(skip_sum);
                n_phase  = PH_KEYCNT;
            end
            PH_KEYCNT: begin
                n_run   = i_word;
                n_phase = (i_word == '0) ? PH_PIXCNT : PH_KEYPIX;
            end
            PH_KEYPIX: begin
                pixel_step = 1'b1;
                n_run      = r_run - 1'b1;
                if (n_run == '0) begin
                    n_phase = PH_PIXCNT;
                end
            end
            PH_PIXCNT: begin
                n_run = i_word;
                if (i_word == '0) begin
                    do_seg = 1'b1;
                end else begin
                    n_phase = PH_PIX;
                end
            end
            PH_PIX: begin
                pixel_step = 1'b1;
                n_run      = r_run - 1'b1;
                if (n_run == '0) begin
                    do_seg = 1'b1;
                end
            end
            PH_IDLE: begin
                finished = 1'b1;
            end
            default: begin
                finished = 1'b1;
            end
        endcase

        pixel_hit = pixel_step && (17'(r_column) < 17'(r_width));
        if (pixel_step && (17'(r_column) < MAX_WIDE)) begin
            n_column = r_column + 1'b1;
        end

        if (do_seg) begin
            n_seg = r_seg - 1'b1;
            if (n_seg == '0) begin
                do_line = 1'b1;
            end else begin
                n_phase = PH_SKIP;
            end
        end

        if (do_line) begin
            n_row = row_inc;
            if (17'(row_inc) >= 17'(r_height)) begin
                complete = 1'b1;
                n_phase  = PH_IDLE;
            end else begin
                n_phase = PH_LINELEN;
            end
        end

        if (n_phase == PH_IDLE) begin
            finished = 1'b1;
        end

        if (i_last) begin
            trunc   = !finished;
            n_phase = PH_WIDTH;
        end
    end

    always_comb begin
        res_prim              = '0;
        res_done              = '0;
        res_trunc             = '0;
        res_done.kind         = rlsd_pkg::KIND_DONE;
        res_trunc.kind        = rlsd_pkg::KIND_TRUNC;
        res_trunc.img_width   = rlsd_pkg::sat13(n_width);
        res_trunc.img_height  = rlsd_pkg::sat13(n_height);
        if (pixel_hit) begin
            res_prim.kind  = rlsd_pkg::KIND_PIXEL;
            res_prim.pix_x = rlsd_pkg::COORD_W'(r_column);
            res_prim.pix_y = rlsd_pkg::COORD_W'(r_row);
            res_prim.red   = rlsd_pkg::expand5(i_word[15:11]);
            res_prim.green = rlsd_pkg::expand6(i_word[10:5]);
            res_prim.blue  = rlsd_pkg::expand5(i_word[4:0]);
        end else begin
            res_prim.kind       = bad_res ? rlsd_pkg::KIND_BAD_DIMS : rlsd_pkg::KIND_DIMS;
            res_prim.img_width  = rlsd_pkg::sat13(n_width);
            res_prim.img_height = rlsd_pkg::sat13(n_height);
        end

        has_prim   = pixel_hit || dim_res || bad_res;
        res_second = complete ? res_done : res_trunc;
        o_count    = 2'(has_prim) + 2'(complete) + 2'(trunc);

        o_res0              = has_prim ? res_prim : res_second;
        o_res0.final_result = (o_count == 2'd1);
        o_res1              = res_second;
        o_res1.final_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WIDTH;
            r_width  <= '0;
            r_height <= '0;
            r_row    <= '0;
            r_seg    <= '0;
            r_run    <= '0;
            r_column <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
            r_row    <= n_row;
            r_seg    <= n_seg;
            r_run    <= n_run;
            r_column <= n_column;
        end
    end

endmodule

// ----- design/rle_sprite_rgb565_decoder.sv -----
// Top level of the run-length RGB565 sprite decoder: input skid stage, parser and output beats.
//
// The slave channel takes one 16-bit blob word per beat, with tlast on the final word of a blob.
// Each word causes zero, one or two results on the master channel: a pixel write, the image
// dimensions, a bad-dimension error, image completion or truncation. tuser carries the result
// kind, and tlast marks the last result caused by one input word.
// An accepted word waits in the input register, or behind it in the skid register, until the
// parser consumes it; its first result beat is then registered in the output stage.
// The block takes one word per cycle while the output is not stalled; a word that causes two
// results occupies the output for two beats and holds the parser until its first beat is taken.
// After reset the parser awaits the width word of a new blob and both channels are empty.
// When the receiver stalls, one result beat and one pending second beat are held, the input
// stage buffers up to two words, and s_axis_tready falls until the output drains.
`include "assert_macros.svh"

module rle_sprite_rgb565_decoder #(
    parameter int MAX_SIDE = rlsd_pkg::MAX_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // word[15:0]
    input  logic [rlsd_pkg::WORD_W-1:0]  s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // pix_x[11:0], pix_y[23:12], red[31:24], green[39:32], blue[47:40],
    // img_width[60:48], img_height[73:61], zero fill[79:74]
    output logic [rlsd_pkg::TDATA_W-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [rlsd_pkg::TUSER_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast
);

    logic                        r_in_valid;
    logic [rlsd_pkg::WORD_W-1:0] r_in_word;
    logic                        r_in_last;
    logic                        r_sk_valid;
    logic [rlsd_pkg::WORD_W-1:0] r_sk_word;
    logic                        r_sk_last;
    logic                        r_out_valid;
    rlsd_pkg::t_result           r_out;
    logic                        r_pend_valid;
    rlsd_pkg::t_result           r_pend;

    logic              s_fire;
    logic              out_fire;
    logic              can_push;
    logic              consume;
    rlsd_pkg::t_result core_res0;
    rlsd_pkg::t_result core_res1;
    logic [1:0]        core_count;

    assign s_axis_tready = !r_sk_valid;
    assign s_fire        = s_axis_tvalid && !r_sk_valid;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign can_push      = !r_pend_valid && (!r_out_valid || m_axis_tready);
    assign consume       = r_in_valid && can_push;

    rlsd_core #(
        .MAX_SIDE (MAX_SIDE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_word  (r_in_word),
        .i_last  (r_in_last),
        .o_res0  (core_res0),
        .o_res1  (core_res1),
        .o_count (core_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (consume) begin
            if (r_sk_valid) begin
                r_in_word  <= r_sk_word;
                r_in_last  <= r_sk_last;
                r_sk_valid <= 1'b0;
            end else if (s_fire) begin
                r_in_word <= s_axis_tdata;
                r_in_last <= s_axis_tlast;
            end else begin
                r_in_valid <= 1'b0;
            end
        end else if (s_fire) begin
            if (!r_in_valid) begin
                r_in_valid <= 1'b1;
                r_in_word  <= s_axis_tdata;
                r_in_last  <= s_axis_tlast;
            end else begin
                r_sk_valid <= 1'b1;
                r_sk_word  <= s_axis_tdata;
                r_sk_last  <= s_axis_tlast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                r_out_valid  <= r_pend_valid;
                r_out        <= r_pend;
                r_pend_valid <= 1'b0;
            end
            if (consume && (core_count != 2'd0)) begin
                r_out_valid  <= 1'b1;
                r_out        <= core_res0;
                r_pend       <= core_res1;
                r_pend_valid <= (core_count == 2'd2);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.final_result;
    assign m_axis_tdata  = {6'd0, r_out.img_height, r_out.img_width, r_out.blue,
                            r_out.green, r_out.red, r_out.pix_y, r_out.pix_x};

    `RLSD_ASSERT_SAME(a_pend_needs_out, i_clk, i_rst_n, r_pend_valid, r_out_valid)
    `RLSD_ASSERT_SAME(a_skid_needs_main, i_clk, i_rst_n, r_sk_valid, r_in_valid)
    `RLSD_ASSERT_NEXT(a_two_results_pend, i_clk, i_rst_n, consume && (core_count == 2'd2),
        r_pend_valid && r_out_valid)
    `RLSD_ASSERT_SAME(a_count_range, i_clk, i_rst_n, r_in_valid, core_count != 2'd3)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the run-length RGB565 sprite decoder.
module tb_top;

    localparam int MAX_SIDE   = rlsd_pkg::MAX_SIDE_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int ITEM_GOAL  = 540;

    typedef enum logic [3:0] {
        P_WIDTH,
        P_HEIGHT,
        P_LINE_LEN,
        P_SEG_COUNT,
        P_SKIP,
        P_KEY_COUNT,
        P_KEY_PIX,
        P_PLAIN_COUNT,
        P_PLAIN_PIX,
        P_IGNORE
    } t_parse;

    typedef struct packed {
        logic [rlsd_pkg::WORD_W-1:0] word;
        logic                        last;
        logic                        hold;
    } t_blob_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [rlsd_pkg::WORD_W-1:0]   s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [rlsd_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic [rlsd_pkg::TUSER_W-1:0]  m_axis_tuser;
    logic                          m_axis_tlast;

    t_blob_word         pending_words[$];
    rlsd_pkg::t_result  expected_results[$];
    t_blob_word         next_word;

    t_parse            parse_state = P_WIDTH;
    logic [15:0]       sprite_w = '0;
    logic [15:0]       sprite_h = '0;
    logic [12:0]       cur_row = '0;
    logic [15:0]       segs_left = '0;
    logic [15:0]       pix_left = '0;
    logic [12:0]       cur_col = '0;

    int unsigned words_total = 0;
    int unsigned words_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    bit          word_taken = 1'b0;
    bit          result_taken = 1'b0;
    bit          progress;
    rlsd_pkg::t_result got;
    rlsd_pkg::t_result want;

    rle_sprite_rgb565_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [rlsd_pkg::DIM_W-1:0] clip_dim(input logic [15:0] v);
        return (v > 16'd8191) ? 13'd8191 : v[12:0];
    endfunction

    task automatic emit(input rlsd_pkg::t_kind k, input logic [11:0] x, input logic [11:0] y,
                        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                        input logic [12:0] w, input logic [12:0] h);
        rlsd_pkg::t_result res;
        res.kind         = k;
        res.pix_x        = x;
        res.pix_y        = y;
        res.red          = r;
        res.green        = g;
        res.blue         = b;
        res.img_width    = w;
        res.img_height   = h;
        res.final_result = 1'b0;
        expected_results.push_back(res);
    endtask

    task automatic paint(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if (cur_col < sprite_w) begin
            r = 8'((int'(c[15:11]) * 255) / 31);
            g = 8'((int'(c[10:5]) * 255) / 63);
            b = 8'((int'(c[4:0]) * 255) / 31);
            emit(rlsd_pkg::KIND_PIXEL, cur_col[11:0], cur_row[11:0], r, g, b, '0, '0);
        end
        if (cur_col < MAX_SIDE) begin
            cur_col = cur_col + 13'd1;
        end
    endtask

    task automatic close_line();
        cur_row = cur_row + 13'd1;
        if (cur_row >= sprite_h) begin
            emit(rlsd_pkg::KIND_DONE, '0, '0, '0, '0, '0, '0, '0);
            parse_state = P_IGNORE;
        end else begin
            parse_state = P_LINE_LEN;
        end
    endtask

    task automatic close_segment();
        segs_left = segs_left - 16'd1;
        if (segs_left == 0) begin
            close_line();
        end else begin
            parse_state = P_SKIP;
        end
    endtask

    task automatic decode_word(input logic [15:0] w, input logic last);
        int                prior_count;
        int                col_sum;
        bit                ended;
        rlsd_pkg::t_result tail;
        prior_count = expected_results.size();
        ended = 1'b0;
        case (parse_state)
            P_WIDTH: begin
                sprite_w = w;
                sprite_h = '0;
                parse_state = P_HEIGHT;
            end
            P_HEIGHT: begin
                sprite_h = w;
                if (sprite_w == 0 || sprite_h == 0 || sprite_w > MAX_SIDE ||
                    sprite_h > MAX_SIDE) begin
                    emit(rlsd_pkg::KIND_BAD_DIMS, '0, '0, '0, '0, '0, clip_dim(sprite_w),
                         clip_dim(sprite_h));
                    parse_state = P_IGNORE;
                end else begin
                    emit(rlsd_pkg::KIND_DIMS, '0, '0, '0, '0, '0, clip_dim(sprite_w),
                         clip_dim(sprite_h));
                    cur_row = '0;
                    parse_state = P_LINE_LEN;
                end
            end
            P_LINE_LEN: parse_state = P_SEG_COUNT;
            P_SEG_COUNT: begin
                segs_left = w;
                cur_col = '0;
                if (w == 0) begin
                    close_line();
                end else begin
                    parse_state = P_SKIP;
                end
            end
            P_SKIP: begin
                col_sum = int'(cur_col) + int'(w);
                cur_col = (col_sum > MAX_SIDE) ? 13'(MAX_SIDE) : 13'(col_sum);
                parse_state = P_KEY_COUNT;
            end
            P_KEY_COUNT: begin
                pix_left = w;
                parse_state = (w == 0) ? P_PLAIN_COUNT : P_KEY_PIX;
            end
            P_KEY_PIX: begin
                paint(w);
                pix_left = pix_left - 16'd1;
                if (pix_left == 0) begin
                    parse_state = P_PLAIN_COUNT;
                end
            end
            P_PLAIN_COUNT: begin
                pix_left = w;
                if (w == 0) begin
                    close_segment();
                end else begin
                    parse_state = P_PLAIN_PIX;
                end
            end
            P_PLAIN_PIX: begin
                paint(w);
                pix_left = pix_left - 16'd1;
                if (pix_left == 0) begin
                    close_segment();
                end
            end
            default: ended = 1'b1;
        endcase
        if (parse_state == P_IGNORE) begin
            ended = 1'b1;
        end
        if (last) begin
            if (!ended) begin
                emit(rlsd_pkg::KIND_TRUNC, '0, '0, '0, '0, '0, clip_dim(sprite_w),
                     clip_dim(sprite_h));
            end
            parse_state = P_WIDTH;
        end
        if (expected_results.size() > prior_count) begin
            tail = expected_results.pop_back();
            tail.final_result = 1'b1;
            expected_results.push_back(tail);
        end
    endtask

    task automatic add_word(input logic [15:0] w, input logic last, input logic hold);
        t_blob_word item;
        item.word = w;
        item.last = last;
        item.hold = hold;
        pending_words.push_back(item);
    endtask

    // A cut of -1 truncates at a random point; extras are ignored words after the image.
    task automatic queue_sprite(input int width, input int height, input int lines,
                                input int cut, input int extras, input bit pause);
        logic [15:0] blob[$];
        int          segs;
        int          count;
        int          keep;
        blob.push_back(16'(width));
        blob.push_back(16'(height));
        for (int ln = 0; ln < lines; ln++) begin
            segs = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
            blob.push_back(16'($urandom));
            blob.push_back(16'(segs));
            for (int s = 0; s < segs; s++) begin
                blob.push_back(($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 3)));
                count = $urandom_range(0, 3);
                blob.push_back(16'(count));
                repeat (count) blob.push_back(16'($urandom));
                count = $urandom_range(0, 4);
                blob.push_back(16'(count));
                repeat (count) blob.push_back(16'($urandom));
            end
        end
        if (cut < 0) begin
            keep = $urandom_range(1, blob.size());
            while (blob.size() > keep) void'(blob.pop_back());
        end
        repeat (extras) blob.push_back(16'($urandom));
        foreach (blob[i]) begin
            add_word(blob[i], i == blob.size() - 1, pause && i == 0);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (word_taken || !s_axis_tvalid) begin
                word_taken = 1'b0;
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap--;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].hold && expected_results.size() != 0)) begin
                    next_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.word;
                    s_axis_tlast  <= next_word.last;
                    send_gap = send_burst ? 0 : $urandom_range(0, 14);
                    if ($urandom_range(0, 31) == 0) begin
                        send_burst = !send_burst;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (result_taken) begin
                result_taken = 1'b0;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 31) == 0) begin
                    recv_burst = !recv_burst;
                end
            end
            if (recv_stall > 0) begin
                m_axis_tready <= 1'b0;
                recv_stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_word(s_axis_tdata, s_axis_tlast);
                words_accepted++;
                word_taken = 1'b1;
                progress = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = rlsd_pkg::t_kind'(m_axis_tuser);
                got.pix_x        = m_axis_tdata[11:0];
                got.pix_y        = m_axis_tdata[23:12];
                got.red          = m_axis_tdata[31:24];
                got.green        = m_axis_tdata[39:32];
                got.blue         = m_axis_tdata[47:40];
                got.img_width    = m_axis_tdata[60:48];
                got.img_height   = m_axis_tdata[73:61];
                got.final_result = m_axis_tlast;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result beat: kind %0d tdata %h last %0b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("Mismatch: expected kind %0d x %0d y %0d rgb %0d/%0d/%0d",
                                   want.kind, want.pix_x, want.pix_y, want.red, want.green,
                                   want.blue);
                            $display(" dims %0dx%0d last %0b",
                                     want.img_width, want.img_height, want.final_result);
                            $write("          actual   kind %0d x %0d y %0d rgb %0d/%0d/%0d",
                                   got.kind, got.pix_x, got.pix_y, got.red, got.green,
                                   got.blue);
                            $display(" dims %0dx%0d last %0b",
                                     got.img_width, got.img_height, got.final_result);
                        end
                    end
                end
                result_taken = 1'b1;
                progress = 1'b1;
            end
            if (progress || (pending_words.size() == 0 && !s_axis_tvalid &&
                             expected_results.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        int  mode;
        int  bw;
        int  bh;
        int  n;
        bit  pause;
        bit  first_pause;

        // Zero width, then both sides far beyond the limit with a trailing ignored word.
        add_word(16'd0, 1'b0, 1'b0);
        add_word(16'd5, 1'b1, 1'b0);
        add_word(16'hFFFF, 1'b0, 1'b0);
        add_word(16'hFFFF, 1'b0, 1'b0);
        add_word(16'h1234, 1'b1, 1'b0);
        // Blob that ends on its width word.
        add_word(16'd7, 1'b1, 1'b0);
        // Full-width sprite: writes at the right edge, then a pixel past the width.
        add_word(16'd4096, 1'b0, 1'b0);
        add_word(16'd1, 1'b0, 1'b0);
        add_word(16'hFFFF, 1'b0, 1'b0);
        add_word(16'd1, 1'b0, 1'b0);
        add_word(16'd4094, 1'b0, 1'b0);
        add_word(16'd1, 1'b0, 1'b0);
        add_word(16'hFFFF, 1'b0, 1'b0);
        add_word(16'd2, 1'b0, 1'b0);
        add_word(16'h0000, 1'b0, 1'b0);
        add_word(16'h07E0, 1'b1, 1'b0);
        // Empty line, a segment with empty key run, then words after completion.
        add_word(16'd3, 1'b0, 1'b0);
        add_word(16'd2, 1'b0, 1'b0);
        add_word(16'd0, 1'b0, 1'b0);
        add_word(16'd0, 1'b0, 1'b0);
        add_word(16'd5, 1'b0, 1'b0);
        add_word(16'd1, 1'b0, 1'b0);
        add_word(16'd0, 1'b0, 1'b0);
        add_word(16'd0, 1'b0, 1'b0);
        add_word(16'd1, 1'b0, 1'b0);
        add_word(16'h001F, 1'b0, 1'b0);
        add_word(16'hF800, 1'b0, 1'b0);
        add_word(16'h5555, 1'b1, 1'b0);

        first_pause = 1'b1;
        while (pending_words.size() < ITEM_GOAL) begin
            mode = $urandom_range(0, 19);
            pause = first_pause || ($urandom_range(0, 9) == 0);
            first_pause = 1'b0;
            bw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_SIDE)
                                             : $urandom_range(1, 12);
            if (mode < 13) begin
                bh = $urandom_range(1, 4);
                queue_sprite(bw, bh, bh, 0,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, pause);
            end else if (mode < 16) begin
                bh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_SIDE)
                                                 : $urandom_range(1, 4);
                queue_sprite(bw, bh, (bh > 3) ? 3 : bh, -1, 0, pause);
            end else if (mode < 18) begin
                case ($urandom_range(0, 3))
                    0: bw = 0;
                    1: bw = MAX_SIDE + 1;
                    2: bw = 16'hFFFF;
                    default: bw = $urandom_range(1, MAX_SIDE);
                endcase
                bh = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_SIDE + 1, 65535);
                if ($urandom_range(0, 2) == 0 && (bw == 0 || bw > MAX_SIDE)) begin
                    bh = $urandom_range(1, MAX_SIDE);
                end
                n = $urandom_range(0, 2);
                add_word(16'(bw), 1'b0, pause);
                add_word(16'(bh), n == 0, 1'b0);
                for (int i = 0; i < n; i++) begin
                    add_word(16'($urandom), i == n - 1, 1'b0);
                end
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    add_word(16'($urandom), i == n - 1, pause && i == 0);
                end
            end
        end
        words_total = pending_words.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < words_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/rlsd_pkg.sv
design/rlsd_core.sv
design/rle_sprite_rgb565_decoder.sv
tb/tb_top.sv
